// ----- rtl/dotp_pkg.sv -----
// shared types and constants for the dhcp option tlv parser
package dotp_pkg;

  localparam logic [7:0] CODE_PAD    = 8'h00;
  localparam logic [7:0] CODE_END    = 8'hFF;
  localparam logic [7:0] CODE_MASK   = 8'd1;
  localparam logic [7:0] CODE_ROUTER = 8'd3;
  localparam logic [7:0] CODE_DNS    = 8'd6;

  localparam logic [7:0] ADDR_BYTES     = 8'd4;
  localparam logic [7:0] TWO_ADDR_BYTES = 8'd8;

  typedef enum logic [3:0] {
    PH_CODE  = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_IDLE  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] opt_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic [31:0] subnet_mask;
    logic [31:0] router_addr;
    logic [31:0] dns_primary;
    logic [31:0] dns_secondary;
  } addrs_t;

  typedef struct packed {
    logic   valid;
    addrs_t addrs;
  } result_t;

endpackage

// ----- rtl/dotp_if.sv -----
// channel interfaces for option bytes in and captured addresses out
interface dotp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opt_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output opt_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input opt_byte, input first_byte, input last_byte,
                output ready);
endinterface

interface dotp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] subnet_mask;
  logic [31:0] router_addr;
  logic [31:0] dns_primary;
  logic [31:0] dns_secondary;

  modport source (output valid, output subnet_mask, output router_addr,
                  output dns_primary, output dns_secondary, input ready);
  modport sink (input valid, input subnet_mask, input router_addr,
                input dns_primary, input dns_secondary, output ready);
endinterface

// ----- rtl/dotp_in_stage.sv -----
// input register stage for option bytes
module dotp_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  dotp_in_if.sink          in_ch,
  input  logic             s1_take,
  output dotp_pkg::stage_t s1
);
  import dotp_pkg::*;

  logic  s1_valid_r;
  logic  s1_valid_nxt;
  item_t s1_item_r;
  logic  load;

  assign in_ch.ready  = !s1_valid_r || s1_take;
  assign load         = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = load ? 1'b1 : (s1_take ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r.opt_byte   <= in_ch.opt_byte;
      s1_item_r.first_byte <= in_ch.first_byte;
      s1_item_r.last_byte  <= in_ch.last_byte;
    end
  end

  assign s1.valid = s1_valid_r;
  assign s1.item  = s1_item_r;
endmodule

// ----- rtl/dotp_walker.sv -----
// option record walker with address capture registers
module dotp_walker (
  input  logic              clk,
  input  logic              rst_n,
  input  dotp_pkg::stage_t  s1,
  input  logic              out_free,
  output logic              s1_take,
  output dotp_pkg::result_t res
);
  import dotp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  cur_code_r, cur_code_nxt;
  logic [7:0]  cur_len_r, cur_len_nxt;
  logic [7:0]  byte_pos_r, byte_pos_nxt;
  logic [63:0] pending_r, pending_nxt;
  addrs_t      addrs_r, addrs_nxt;

  phase_t      ph;
  logic [7:0]  code_e;
  logic [7:0]  len_e;
  logic [7:0]  pos_e;
  logic [63:0] pend_e;
  logic [63:0] pend_sh;
  logic [7:0]  pos_inc;
  logic [3:0]  kept;
  logic [31:0] first4;
  logic [7:0]  b;
  logic        fire;

  assign b       = s1.item.opt_byte;
  assign fire    = s1.valid && (!s1.item.last_byte || out_free);
  assign s1_take = fire;

  // restart on first byte of an area
  assign ph     = s1.item.first_byte ? PH_CODE : phase_r;
  assign code_e = s1.item.first_byte ? 8'd0 : cur_code_r;
  assign len_e  = s1.item.first_byte ? 8'd0 : cur_len_r;
  assign pos_e  = s1.item.first_byte ? 8'd0 : byte_pos_r;
  assign pend_e = s1.item.first_byte ? 64'd0 : pending_r;

  assign pend_sh = (pos_e < TWO_ADDR_BYTES) ? {pend_e[55:0], b} : pend_e;
  assign pos_inc = pos_e + 8'd1;
  assign kept    = (len_e >= TWO_ADDR_BYTES) ? 4'd8 : len_e[3:0];

  always_comb begin
    unique case (kept)
      4'd4:    first4 = pend_sh[31:0];
      4'd5:    first4 = pend_sh[39:8];
      4'd6:    first4 = pend_sh[47:16];
      4'd7:    first4 = pend_sh[55:24];
      default: first4 = pend_sh[63:32];
    endcase
  end

  always_comb begin
    phase_nxt    = ph;
    cur_code_nxt = code_e;
    cur_len_nxt  = len_e;
    byte_pos_nxt = pos_e;
    pending_nxt  = pend_e;
    addrs_nxt    = addrs_r;
    unique case (ph)
      PH_CODE: begin
        if (b == CODE_END) begin
          phase_nxt = PH_IDLE;
        end else if (b != CODE_PAD) begin
          cur_code_nxt = b;
          phase_nxt    = PH_LEN;
        end
      end
      PH_LEN: begin
        cur_len_nxt  = b;
        byte_pos_nxt = 8'd0;
        pending_nxt  = 64'd0;
        phase_nxt    = (b == 8'd0) ? PH_CODE : PH_VALUE;
      end
      PH_VALUE: begin
        pending_nxt  = pend_sh;
        byte_pos_nxt = pos_inc;
        if (pos_inc >= len_e) begin
          phase_nxt = PH_CODE;
          if (len_e >= ADDR_BYTES) begin
            if (code_e == CODE_MASK) begin
              addrs_nxt.subnet_mask = first4;
            end else if (code_e == CODE_ROUTER) begin
              addrs_nxt.router_addr = first4;
            end else if (code_e == CODE_DNS) begin
              addrs_nxt.dns_primary = first4;
              if (len_e >= TWO_ADDR_BYTES) begin
                addrs_nxt.dns_secondary = pend_sh[31:0];
              end
            end
          end
        end
      end
      PH_IDLE: begin
      end
      default: begin
      end
    endcase
    if (s1.item.last_byte) begin
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CODE;
      cur_code_r <= 8'd0;
      cur_len_r  <= 8'd0;
      byte_pos_r <= 8'd0;
      pending_r  <= 64'd0;
      addrs_r    <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      cur_code_r <= cur_code_nxt;
      cur_len_r  <= cur_len_nxt;
      byte_pos_r <= byte_pos_nxt;
      pending_r  <= pending_nxt;
      addrs_r    <= addrs_nxt;
    end
  end

  assign res.valid = fire && s1.item.last_byte;
  assign res.addrs = addrs_nxt;
endmodule

// ----- rtl/dotp_out_stage.sv -----
// result register stage for captured addresses
module dotp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  dotp_pkg::result_t res,
  output logic              out_free,
  dotp_out_if.source        out_ch
);
  import dotp_pkg::*;

  logic   out_valid_r;
  logic   out_valid_nxt;
  addrs_t out_addrs_r;

  assign out_free      = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = res.valid ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_addrs_r <= res.addrs;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.subnet_mask   = out_addrs_r.subnet_mask;
  assign out_ch.router_addr   = out_addrs_r.router_addr;
  assign out_ch.dns_primary   = out_addrs_r.dns_primary;
  assign out_ch.dns_secondary = out_addrs_r.dns_secondary;
endmodule

// ----- rtl/dhcp_option_tlv_parser.sv -----
// top level of the dhcp option tlv parser
//
// in_ch carries one byte of a dhcp options area per transaction, with
// first_byte marking the start of an area and last_byte its final byte.
// the block walks code, length and value records, skipping pad codes and
// ignoring everything after the end code, and captures subnet mask, router
// and two name servers once the last value byte of a record has arrived.
// out_ch carries one transaction with all four captured addresses for every
// input byte marked last_byte.
// a byte is registered on acceptance and processed by the walker from the input
// register; the result for a last-marked byte is registered in the result
// register and then presented valid on out_ch.
// one byte is accepted per cycle unless a last-marked byte waits in the input
// register for the result register; the walker update is combinational between them.
// reset clears all captured addresses and the valid flags of both stages, and
// leaves the walker expecting a code byte.
// while out_ch stalls with a result held, bytes without last_byte keep
// flowing; a last-marked byte waits in the input register and in_ch.ready
// then drops until the result is taken.
module dhcp_option_tlv_parser (
  input  logic       clk,
  input  logic       rst_n,
  dotp_in_if.sink    in_ch,
  dotp_out_if.source out_ch
);
  import dotp_pkg::*;

  stage_t  s1;
  result_t res;
  logic    s1_take;
  logic    out_free;

  dotp_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .s1_take (s1_take),
    .s1      (s1)
  );

  dotp_walker u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1       (s1),
    .out_free (out_free),
    .s1_take  (s1_take),
    .res      (res)
  );

  dotp_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> out_free)
    else $error("result produced while output register still held");

  a_res_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (s1.valid && s1.item.last_byte))
    else $error("result without a last-marked byte");

  a_plain_byte_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1.valid && !s1.item.last_byte) |-> s1_take)
    else $error("non-final byte held in input register");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> s1.valid)
    else $error("accepted byte missing from input register");
endmodule
